>>> rtl/fixed_point_alu_assert.svh
// assertion helpers shared by the alu front and back modules
`ifndef FIXED_POINT_ALU_ASSERT_SVH
`define FIXED_POINT_ALU_ASSERT_SVH

// checked only while out of reset
`define FPA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked at every edge, reset included
`define FPA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

>>> rtl/fpa_pkg.sv
// ----------------------------------------------------------------------------
// fpa_pkg
// shared opcodes, queue entry type and defaults of the fixed-point alu
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package fpa_pkg;

  localparam int FracBitsDef = 8;
  localparam int QDepth      = 2;

  typedef enum logic [3:0] {
    CMD_ADD      = 4'd0,
    CMD_SUB      = 4'd1,
    CMD_MUL      = 4'd2,
    CMD_DIV      = 4'd3,
    CMD_EQ       = 4'd4,
    CMD_NE       = 4'd5,
    CMD_GT       = 4'd6,
    CMD_LT       = 4'd7,
    CMD_GE       = 4'd8,
    CMD_LE       = 4'd9,
    CMD_MIN      = 4'd10,
    CMD_MAX      = 4'd11,
    CMD_INC      = 4'd12,
    CMD_DEC      = 4'd13,
    CMD_FROM_INT = 4'd14,
    CMD_TO_INT   = 4'd15
  } cmd_e;

  typedef struct packed {
    cmd_e               cmd;
    logic signed [31:0] a;
    logic signed [31:0] b;
    logic               is_div;
    logic               div_zero;
  } item_t;

endpackage

>>> rtl/fpa_front.sv
// ----------------------------------------------------------------------------
// fpa_front
// accepts commands, classifies them and queues them for the execute side
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "fixed_point_alu_assert.svh"
module fpa_front import fpa_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  input  logic [3:0]         cmd_i,
  input  logic signed [31:0] operand_a_i,
  input  logic signed [31:0] operand_b_i,
  output logic               busy,
  output item_t              item_o,
  output logic               item_valid_o,
  input  logic               item_pop_i
);

  localparam int PtrW = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int CntW = $clog2(QDepth + 1);

  item_t            mem_q [QDepth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             push, pop, full;
  item_t            new_item;

  assign full         = (cnt_q == CntW'(QDepth));
  assign busy         = full;
  assign push         = start && !full;
  assign item_valid_o = (cnt_q != '0);
  assign pop          = item_pop_i && item_valid_o;
  assign item_o       = mem_q[rd_ptr_q];

  always_comb begin
    new_item.cmd      = cmd_e'(cmd_i);
    new_item.a        = operand_a_i;
    new_item.b        = operand_b_i;
    new_item.is_div   = (cmd_e'(cmd_i) == CMD_DIV);
    new_item.div_zero = (operand_b_i == '0);
    cnt_d = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= new_item;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(QDepth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(QDepth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
    end
  end

  `FPA_ASSERT(a_cnt_bound, cnt_q <= CntW'(QDepth), "queue count beyond depth")
  `FPA_ASSERT(a_cnt_up, push && !pop |=> cnt_q == $past(cnt_q) + CntW'(1), "push lost")
  `FPA_ASSERT(a_cnt_down, pop && !push |=> cnt_q == $past(cnt_q) - CntW'(1), "pop lost")

endmodule

>>> rtl/fpa_back.sv
// ----------------------------------------------------------------------------
// fpa_back
// execute side: multiplier, bit-serial divider and result register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "fixed_point_alu_assert.svh"
module fpa_back import fpa_pkg::*; #(
  parameter int FRAC_BITS = FracBitsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  item_t              item_i,
  input  logic               item_valid_i,
  output logic               item_pop_o,
  output logic               done_o,
  output logic signed [31:0] result_value_o,
  output logic               compare_true_o,
  output logic               overflowed_o,
  output logic               divided_by_zero_o
);

  localparam int DW   = 32 + FRAC_BITS;
  localparam int CntW = $clog2(DW + 1);
  localparam logic signed [63:0] Bias = (64'sd1 <<< FRAC_BITS) - 64'sd1;

  logic               s1_valid_q;
  item_t              s1_q;
  logic signed [63:0] prod_q;
  logic [DW-1:0]      dvd_q, quo_q;
  logic [31:0]        dvs_q, rem_q;
  logic               neg_q;
  logic [CntW-1:0]    cnt_q;
  logic               s1_done;

  logic [31:0]        mag_a, mag_b;
  logic [32:0]        rem_sh, rem_sub;
  logic signed [63:0] a64, b64, r, q64;
  logic               cmp;

  assign s1_done    = (cnt_q == '0);
  assign item_pop_o = !s1_valid_q || s1_done;
  assign mag_a      = item_i.a[31] ? 32'(-item_i.a) : item_i.a;
  assign mag_b      = item_i.b[31] ? 32'(-item_i.b) : item_i.b;
  assign rem_sh     = {rem_q, dvd_q[DW-1]};
  assign rem_sub    = rem_sh - {1'b0, dvs_q};

  always_comb begin
    a64 = {{32{s1_q.a[31]}}, s1_q.a};
    b64 = {{32{s1_q.b[31]}}, s1_q.b};
    q64 = neg_q ? -$signed(64'(quo_q)) : $signed(64'(quo_q));
    r   = '0;
    cmp = 1'b0;
    case (s1_q.cmd)
      CMD_ADD:      r = a64 + b64;
      CMD_SUB:      r = a64 - b64;
      CMD_MUL:      r = (prod_q + (prod_q[63] ? Bias : 64'sd0)) >>> FRAC_BITS;
      CMD_DIV:      r = s1_q.div_zero ? 64'sd0 : q64;
      CMD_EQ:       cmp = (s1_q.a == s1_q.b);
      CMD_NE:       cmp = (s1_q.a != s1_q.b);
      CMD_GT:       cmp = (s1_q.a > s1_q.b);
      CMD_LT:       cmp = (s1_q.a < s1_q.b);
      CMD_GE:       cmp = (s1_q.a >= s1_q.b);
      CMD_LE:       cmp = (s1_q.a <= s1_q.b);
      CMD_MIN:      r = (s1_q.a <= s1_q.b) ? a64 : b64;
      CMD_MAX:      r = (s1_q.a >= s1_q.b) ? a64 : b64;
      CMD_INC:      r = a64 + 64'sd1;
      CMD_DEC:      r = a64 - 64'sd1;
      CMD_FROM_INT: r = a64 <<< FRAC_BITS;
      CMD_TO_INT:   r = a64 >>> FRAC_BITS;
      default:      r = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (item_pop_o && item_valid_i) begin
      s1_q   <= item_i;
      prod_q <= item_i.a * item_i.b;
      dvd_q  <= DW'(mag_a) << FRAC_BITS;
      dvs_q  <= mag_b;
      quo_q  <= '0;
      rem_q  <= '0;
      neg_q  <= item_i.a[31] ^ item_i.b[31];
    end else if (!s1_done) begin
      dvd_q <= dvd_q << 1;
      if (!rem_sub[32]) begin
        rem_q <= rem_sub[31:0];
        quo_q <= {quo_q[DW-2:0], 1'b1};
      end else begin
        rem_q <= rem_sh[31:0];
        quo_q <= {quo_q[DW-2:0], 1'b0};
      end
    end
    result_value_o    <= r[31:0];
    compare_true_o    <= cmp;
    overflowed_o      <= !((&r[63:31]) || !(|r[63:31]));
    divided_by_zero_o <= s1_q.is_div && s1_q.div_zero;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      cnt_q      <= '0;
      done_o     <= 1'b0;
    end else begin
      done_o <= s1_valid_q && s1_done;
      if (item_pop_o) begin
        s1_valid_q <= item_valid_i;
        cnt_q      <= (item_valid_i && item_i.is_div && !(item_i.b == '0)) ?
                      CntW'(DW) : '0;
      end else if (!s1_done) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  `FPA_ASSERT(a_flags_excl, done_o |-> !(divided_by_zero_o && overflowed_o), "dz with ovf")
  `FPA_ASSERT(a_cmp_zero, done_o && compare_true_o |-> result_value_o == '0, "cmp value")
  `FPA_ASSERT(a_div_hold, s1_valid_q && !s1_done |=> $stable(s1_q), "item moved mid divide")
  `FPA_ASSERT(a_div_only, !s1_done |-> s1_valid_q && s1_q.is_div, "stray divide count")

endmodule

>>> rtl/fixed_point_alu.sv
// ----------------------------------------------------------------------------
// fixed_point_alu
// signed 32-bit fixed-point alu with FRAC_BITS fraction bits
// ----------------------------------------------------------------------------
// usage:
//   a transaction is taken when start is high and busy is low; cmd_i,
//   operand_a_i and operand_b_i are sampled at that edge
//   every transaction yields one result, shown for one cycle with done_o;
//   the receiver cannot stall, so results are never held back
//   the front queues up to two classified transactions; busy rises only
//   when that queue is full
// execution:
//   each command passes the queue, the execute stage and the result registers
//   before done_o; a divide by a nonzero operand holds the execute stage
//   (one quotient bit per cycle in the shift-subtract divider)
// throughput:
//   one transaction per cycle while no divide is in flight
// reset:
//   rst_ni clears the queue and the execute stage; nothing is in flight
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module fixed_point_alu import fpa_pkg::*; #(
  parameter int FRAC_BITS = FracBitsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [3:0]         cmd_i,
  input  logic signed [31:0] operand_a_i,
  input  logic signed [31:0] operand_b_i,
  output logic               done_o,
  output logic signed [31:0] result_value_o,
  output logic               compare_true_o,
  output logic               overflowed_o,
  output logic               divided_by_zero_o
);

  // queue entry handed from front to execute
  item_t item;
  logic  item_valid;
  logic  item_pop;

  // front: accept and classify
  fpa_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .cmd_i        (cmd_i),
    .operand_a_i  (operand_a_i),
    .operand_b_i  (operand_b_i),
    .busy         (busy),
    .item_o       (item),
    .item_valid_o (item_valid),
    .item_pop_i   (item_pop)
  );

  // back: execute and register the result
  fpa_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .item_i            (item),
    .item_valid_i      (item_valid),
    .item_pop_o        (item_pop),
    .done_o            (done_o),
    .result_value_o    (result_value_o),
    .compare_true_o    (compare_true_o),
    .overflowed_o      (overflowed_o),
    .divided_by_zero_o (divided_by_zero_o)
  );

endmodule

>>> sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the fixed-point alu: directed corner cases, then
// random transactions under varying sender gaps, checked in order
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

// expected alu outcome of one transaction
typedef struct {
  logic signed [31:0] value;
  logic               cmp;
  logic               ovf;
  logic               dz;
} alu_outcome_t;

class alu_scoreboard;
  alu_outcome_t pending[$];
  int           n_errors;
  int           n_checked;

  function new();
    n_errors  = 0;
    n_checked = 0;
  endfunction

  // computes the expected outcome of an accepted transaction
  function void note_input(fpa_pkg::cmd_e op, logic signed [31:0] a,
                           logic signed [31:0] b);
    alu_outcome_t     o;
    longint           wa;
    longint           wb;
    longint           full;
    longint           unit;
    wa   = a;
    wb   = b;
    unit = longint'(1) << fpa_pkg::FracBitsDef;
    full = 0;
    o.cmp = 1'b0;
    o.dz  = 1'b0;
    case (op)
      fpa_pkg::CMD_ADD:      full = wa + wb;
      fpa_pkg::CMD_SUB:      full = wa - wb;
      fpa_pkg::CMD_MUL:      full = (wa * wb) / unit;
      fpa_pkg::CMD_DIV: begin
        if (wb == 0) o.dz = 1'b1;
        else full = (wa * unit) / wb;
      end
      fpa_pkg::CMD_EQ:       o.cmp = (wa == wb);
      fpa_pkg::CMD_NE:       o.cmp = (wa != wb);
      fpa_pkg::CMD_GT:       o.cmp = (wa > wb);
      fpa_pkg::CMD_LT:       o.cmp = (wa < wb);
      fpa_pkg::CMD_GE:       o.cmp = (wa >= wb);
      fpa_pkg::CMD_LE:       o.cmp = (wa <= wb);
      fpa_pkg::CMD_MIN:      full = (wa <= wb) ? wa : wb;
      fpa_pkg::CMD_MAX:      full = (wa >= wb) ? wa : wb;
      fpa_pkg::CMD_INC:      full = wa + 1;
      fpa_pkg::CMD_DEC:      full = wa - 1;
      fpa_pkg::CMD_FROM_INT: full = wa * unit;
      default:               full = wa >>> fpa_pkg::FracBitsDef;
    endcase
    o.value = full[31:0];
    o.ovf   = (full < -64'sd2147483648) || (full > 64'sd2147483647);
    pending.push_back(o);
  endfunction

  function void check_result(logic signed [31:0] value, logic cmp, logic ovf,
                             logic dz);
    alu_outcome_t e;
    if (pending.size() == 0) begin
      $error("result with no transaction pending: value %0d", value);
      n_errors++;
      return;
    end
    e = pending.pop_front();
    n_checked++;
    if (value !== e.value) begin
      $error("result_value expected %0d actual %0d", e.value, value);
      n_errors++;
    end
    if (cmp !== e.cmp) begin
      $error("compare_true expected %0b actual %0b", e.cmp, cmp);
      n_errors++;
    end
    if (ovf !== e.ovf) begin
      $error("overflowed expected %0b actual %0b", e.ovf, ovf);
      n_errors++;
    end
    if (dz !== e.dz) begin
      $error("divided_by_zero expected %0b actual %0b", e.dz, dz);
      n_errors++;
    end
  endfunction
endclass

module tb_top;
  import fpa_pkg::*;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic [3:0]         cmd_i = '0;
  logic signed [31:0] operand_a_i = '0;
  logic signed [31:0] operand_b_i = '0;
  logic               done_o;
  logic signed [31:0] result_value_o;
  logic               compare_true_o;
  logic               overflowed_o;
  logic               divided_by_zero_o;

  alu_scoreboard alu_sb = new();
  int            gap_pct = 0;   // percent chance per check that the sender idles
  int            n_sent = 0;

  always #1 clk_i = ~clk_i;

  fixed_point_alu i_dut (
    .clk_i, .rst_ni, .start, .busy, .cmd_i, .operand_a_i, .operand_b_i,
    .done_o, .result_value_o, .compare_true_o, .overflowed_o, .divided_by_zero_o
  );

  // inputs accepted and results collected at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni && start && !busy) alu_sb.note_input(cmd_e'(cmd_i), operand_a_i, operand_b_i);
    if (rst_ni && done_o)
      alu_sb.check_result(result_value_o, compare_true_o, overflowed_o, divided_by_zero_o);
  end

  // drives one transaction, holding start until it is taken; start stays high
  // straight into the next transaction when no gap follows
  task automatic send_op(cmd_e op, logic signed [31:0] a, logic signed [31:0] b);
    while ($urandom_range(99, 0) < gap_pct) begin
      start <= 1'b0;
      @(negedge clk_i);
    end
    start       <= 1'b1;
    cmd_i       <= op;
    operand_a_i <= a;
    operand_b_i <= b;
    do @(posedge clk_i); while (busy);
    @(negedge clk_i);
    n_sent++;
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (alu_sb.pending.size() != 0) @(negedge clk_i);
  endtask

  // random operand with a bias toward the range ends and small magnitudes
  function automatic logic signed [31:0] pick_operand();
    case ($urandom_range(5, 0))
      0:       return 32'sh7fffffff - $urandom_range(3, 0);
      1:       return 32'sh80000000 + $urandom_range(3, 0);
      2:       return $signed($urandom_range(2048, 0)) - 1024;
      3:       return 32'sd0;
      default: return $urandom();
    endcase
  endfunction

  // random cmds, with divide sent less often since it holds the pipe
  task automatic random_phase(int count, int pct);
    cmd_e op;
    gap_pct = pct;
    repeat (count) begin
      op = cmd_e'($urandom_range(15, 0));
      if (op == CMD_DIV && $urandom_range(3, 0) != 0) op = CMD_ADD;
      send_op(op, pick_operand(), pick_operand());
    end
  endtask

  initial begin
    logic signed [31:0] corners [5];
    corners = '{32'sh7fffffff, 32'sh80000000, 32'sd0, -32'sd1, 32'sd256};
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: every cmd with corner operands, divide by zero, equal operands
    for (int k = 0; k < 16; k++) send_op(cmd_e'(k), corners[k % 5], corners[(k + 1) % 5]);
    send_op(CMD_DIV, 32'sd1000, 32'sd0);
    send_op(CMD_DIV, 32'sh80000000, -32'sd1);
    send_op(CMD_MIN, 32'sd77, 32'sd77);
    send_op(CMD_MAX, -32'sd5, -32'sd5);
    send_op(CMD_MUL, -32'sd3, 32'sd1);
    send_op(CMD_TO_INT, -32'sd1, 32'sd0);
    send_op(CMD_FROM_INT, 32'sh00800000, 32'sd0);
    send_op(CMD_DEC, 32'sh80000000, 32'sd0);
    // sender holds off until the pipe is empty
    wait_drained();

    random_phase(400, 30);
    random_phase(400, 69);
    random_phase(426, 0);
    wait_drained();
    repeat (60) @(negedge clk_i);

    $display("ran %0d transactions, %0d results checked, all cmds with corner operands",
             n_sent, alu_sb.n_checked);
    if (alu_sb.n_errors == 0 && alu_sb.pending.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("FAILURE");
    $finish;
  end

endmodule

>>> sim.f
+incdir+rtl
rtl/fpa_pkg.sv
rtl/fpa_front.sv
rtl/fpa_back.sv
rtl/fixed_point_alu.sv
sim/tb_top.sv
